// ===== rtl/prac_pkg.sv =====
// ----------------------------------------------------------------------------
// prac_pkg
// Shared constants and register indexes for the point rotation block.
// ----------------------------------------------------------------------------
`default_nettype none

package prac_pkg;

	localparam int unsigned ANGLE_BITS    = 9;
	localparam int unsigned HALF_TURN     = 180;
	localparam int unsigned QUARTER_TURN  = HALF_TURN / 2;
	localparam int unsigned FULL_TURN     = HALF_TURN * 2;
	localparam int unsigned TRIG_IDX_BITS = $clog2(QUARTER_TURN + 1);

	localparam int unsigned REG_ADDR_BITS = 2;
	localparam logic [REG_ADDR_BITS-1:0] REG_CENTER_X  = 2'd0;
	localparam logic [REG_ADDR_BITS-1:0] REG_CENTER_Y  = 2'd1;
	localparam logic [REG_ADDR_BITS-1:0] REG_ANGLE_DEG = 2'd2;

	// pi in unsigned q4.60
	localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

endpackage

`default_nettype wire

// ===== rtl/point_rotate_about_center_top.sv =====
// ----------------------------------------------------------------------------
// point_rotate_about_center_top
// Rotates each streamed point by the configured angle about the configured
// center, rounding each coordinate to nearest with halves away from zero.
// Pipeline: one register stage each for fold/lookup, multiply, sum and round,
// from input transaction to m_tvalid.
// Throughput: one transaction per cycle; each stage holds only while the stage
// after it is full and stalled, so bubbles are squeezed out under backpressure.
// Reset: arst_n clears all stage valid bits and the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module point_rotate_about_center_top #(
	parameter int unsigned COORD_BITS     = 16,
	parameter int unsigned TRIG_FRAC_BITS = 16
) (
	input  wire logic clk,
	input  wire logic arst_n,

	input  wire logic cfg_we,
	input  wire logic [prac_pkg::REG_ADDR_BITS-1:0] cfg_addr,
	input  wire logic [((COORD_BITS > prac_pkg::ANGLE_BITS) ?
		COORD_BITS : prac_pkg::ANGLE_BITS)-1:0] cfg_wdata,

	input  wire logic s_tvalid,
	output logic      s_tready,
	// in_x, in_y
	input  wire logic [((2 * COORD_BITS + 7) / 8) * 8 - 1:0] s_tdata,

	output logic      m_tvalid,
	input  wire logic m_tready,
	// out_x, out_y
	output logic [((2 * (COORD_BITS + 2) + 7) / 8) * 8 - 1:0] m_tdata
);

	import prac_pkg::*;

	localparam int unsigned C     = COORD_BITS;
	localparam int unsigned F     = TRIG_FRAC_BITS;
	localparam int unsigned DW    = C + 1;
	localparam int unsigned TW    = F + 2;
	localparam int unsigned PW    = DW + TW;
	localparam int unsigned SW    = PW + 2;
	localparam int unsigned OW    = C + 2;
	localparam int unsigned OUT_W = ((2 * OW + 7) / 8) * 8;

	typedef logic signed [C-1:0]  coord_t;
	typedef logic signed [DW-1:0] delta_t;
	typedef logic signed [TW-1:0] trig_t;
	typedef logic signed [PW-1:0] prod_t;
	typedef logic signed [SW-1:0] sum_t;
	typedef logic signed [OW-1:0] res_t;

	// configuration
	coord_t                center_x_q;
	coord_t                center_y_q;
	logic [ANGLE_BITS-1:0] angle_q;
	logic [ANGLE_BITS-1:0] wr_angle;

	assign wr_angle = (cfg_wdata[ANGLE_BITS-1:0] >= ANGLE_BITS'(FULL_TURN)) ?
		cfg_wdata[ANGLE_BITS-1:0] - ANGLE_BITS'(FULL_TURN) : cfg_wdata[ANGLE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			angle_q    <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_CENTER_X:  center_x_q <= cfg_wdata[C-1:0];
				REG_CENTER_Y:  center_y_q <= cfg_wdata[C-1:0];
				REG_ANGLE_DEG: angle_q    <= wr_angle;
				default: ;
			endcase
		end
	end

	// first-quadrant sine table
	logic [F:0] sin_rom [0:QUARTER_TURN];

	for (genvar k = 0; k <= QUARTER_TURN; k++) begin : g_rom
		// angle in q1.31, then the series to x^17
		localparam logic [63:0] ANG_Q31 =
			(64'(k) * (PI_Q60 >> 29) + 64'd90) / 64'(HALF_TURN);
		localparam logic [63:0] ANG_SQ = (ANG_Q31 * ANG_Q31) >> 31;
		localparam logic [63:0] TERM1  = ((ANG_Q31 * ANG_SQ) >> 31) / 64'd6;
		localparam logic [63:0] TERM2  = ((TERM1 * ANG_SQ) >> 31) / 64'd20;
		localparam logic [63:0] TERM3  = ((TERM2 * ANG_SQ) >> 31) / 64'd42;
		localparam logic [63:0] TERM4  = ((TERM3 * ANG_SQ) >> 31) / 64'd72;
		localparam logic [63:0] TERM5  = ((TERM4 * ANG_SQ) >> 31) / 64'd110;
		localparam logic [63:0] TERM6  = ((TERM5 * ANG_SQ) >> 31) / 64'd156;
		localparam logic [63:0] TERM7  = ((TERM6 * ANG_SQ) >> 31) / 64'd210;
		localparam logic [63:0] TERM8  = ((TERM7 * ANG_SQ) >> 31) / 64'd272;
		localparam logic signed [63:0] SERIES = $signed(ANG_Q31) - $signed(TERM1) +
			$signed(TERM2) - $signed(TERM3) + $signed(TERM4) - $signed(TERM5) +
			$signed(TERM6) - $signed(TERM7) + $signed(TERM8);
		localparam logic [63:0] SER_POS = (SERIES < 0) ? 64'd0 : 64'(SERIES);
		localparam logic [63:0] SIN_RND = (SER_POS + (64'd1 << (30 - F))) >> (31 - F);
		localparam logic [63:0] SIN_VAL =
			(SIN_RND > (64'd1 << F)) ? (64'd1 << F) : SIN_RND;
		assign sin_rom[k] = SIN_VAL[F:0];
	end

	// stage handshake
	logic v_s1, v_s2, v_s3, v_s4;
	logic en_s1, en_s2, en_s3, en_s4;

	assign en_s4    = !v_s4 || m_tready;
	assign en_s3    = !v_s3 || en_s4;
	assign en_s2    = !v_s2 || en_s3;
	assign en_s1    = !v_s1 || en_s2;
	assign s_tready = en_s1;
	assign m_tvalid = v_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (en_s1) v_s1 <= s_tvalid;
			if (en_s2) v_s2 <= v_s1;
			if (en_s3) v_s3 <= v_s2;
			if (en_s4) v_s4 <= v_s3;
		end
	end

	// stage 1: offsets, quadrant fold, table lookup
	coord_t                 in_x, in_y;
	logic [TRIG_IDX_BITS-1:0] fold_idx;
	logic                   sin_neg, cos_neg;
	trig_t                  sin_mag, cos_mag;
	delta_t                 dx_s1, dy_s1;
	trig_t                  sin_s1, cos_s1;

	assign in_x = s_tdata[C-1:0];
	assign in_y = s_tdata[2*C-1:C];

	always_comb begin
		if (angle_q <= ANGLE_BITS'(QUARTER_TURN)) begin
			fold_idx = angle_q[TRIG_IDX_BITS-1:0];
			sin_neg  = 1'b0;
			cos_neg  = 1'b0;
		end else if (angle_q <= ANGLE_BITS'(HALF_TURN)) begin
			fold_idx = TRIG_IDX_BITS'(ANGLE_BITS'(HALF_TURN) - angle_q);
			sin_neg  = 1'b0;
			cos_neg  = 1'b1;
		end else if (angle_q <= ANGLE_BITS'(HALF_TURN + QUARTER_TURN)) begin
			fold_idx = TRIG_IDX_BITS'(angle_q - ANGLE_BITS'(HALF_TURN));
			sin_neg  = 1'b1;
			cos_neg  = 1'b1;
		end else begin
			fold_idx = TRIG_IDX_BITS'(ANGLE_BITS'(FULL_TURN) - angle_q);
			sin_neg  = 1'b1;
			cos_neg  = 1'b0;
		end
		sin_mag = trig_t'({1'b0, sin_rom[fold_idx]});
		cos_mag = trig_t'({1'b0, sin_rom[TRIG_IDX_BITS'(QUARTER_TURN) - fold_idx]});
	end

	always_ff @(posedge clk) begin
		if (en_s1 && s_tvalid) begin
			dx_s1  <= DW'(in_x) - DW'(center_x_q);
			dy_s1  <= DW'(in_y) - DW'(center_y_q);
			sin_s1 <= sin_neg ? -sin_mag : sin_mag;
			cos_s1 <= cos_neg ? -cos_mag : cos_mag;
		end
	end

	// stage 2: products
	prod_t p_xc_s2, p_ys_s2, p_xs_s2, p_yc_s2;

	always_ff @(posedge clk) begin
		if (en_s2 && v_s1) begin
			p_xc_s2 <= PW'(dx_s1) * PW'(cos_s1);
			p_ys_s2 <= PW'(dy_s1) * PW'(sin_s1);
			p_xs_s2 <= PW'(dx_s1) * PW'(sin_s1);
			p_yc_s2 <= PW'(dy_s1) * PW'(cos_s1);
		end
	end

	// stage 3: sums with center
	sum_t rx_s3, ry_s3;

	always_ff @(posedge clk) begin
		if (en_s3 && v_s2) begin
			rx_s3 <= (SW'(center_x_q) <<< F) + SW'(p_xc_s2) - SW'(p_ys_s2);
			ry_s3 <= (SW'(center_y_q) <<< F) + SW'(p_xs_s2) + SW'(p_yc_s2);
		end
	end

	// stage 4: round half away from zero
	function automatic res_t round_away(input sum_t v);
		logic [SW-1:0] mag;
		logic [SW-1:0] rnd;
		mag = v[SW-1] ? SW'(-v) : SW'(v);
		rnd = (mag + (SW'(1) << (F - 1))) >> F;
		return v[SW-1] ? -res_t'(rnd[OW-1:0]) : res_t'(rnd[OW-1:0]);
	endfunction

	res_t out_x_s4, out_y_s4;

	always_ff @(posedge clk) begin
		if (en_s4 && v_s3) begin
			out_x_s4 <= round_away(rx_s3);
			out_y_s4 <= round_away(ry_s3);
		end
	end

	assign m_tdata = OUT_W'({out_y_s4, out_x_s4});

endmodule

`default_nettype wire

// ===== rtl/prac_checker.sv =====
// ----------------------------------------------------------------------------
// prac_checker
// Port-level checks for the point rotation pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module prac_checker #(
	parameter int unsigned DW = 40
) (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          s_tvalid,
	input wire logic          s_tready,
	input wire logic          m_tvalid,
	input wire logic          m_tready,
	input wire logic [DW-1:0] m_tdata
);

	// stalled output transaction holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("output changed while stalled");

	// an empty or draining output stage never blocks the input
	a_in_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input blocked with output free");

	// with the sink ready meanwhile, an accepted transaction reaches the output once it has passed every stage
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) ##1 m_tready ##1 m_tready ##1 m_tready |=> m_tvalid)
		else $error("result missing after pipeline latency");

	// nothing comes out of an empty pipeline
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 4) || $past(m_tvalid, 1) ||
			!$past(s_tready, 1) || !$past(s_tready, 2) || !$past(s_tready, 3) ||
			$past(!m_tready, 1) || $past(!m_tready, 2) || $past(!m_tready, 3) ||
			$past(s_tvalid && s_tready, 5) || $past(s_tvalid && s_tready, 6) ||
			$past(s_tvalid && s_tready, 7))
		else $error("output valid with no input");

endmodule

bind point_rotate_about_center_top prac_checker #(
	.DW($bits(m_tdata))
) u_prac_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire
